@@ rtl/u16l_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u16l_pkg
// Shared types and constants for the UTF-16 index to line unit.
// ----------------------------------------------------------------------------
package u16l_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int CODE_WIDTH      = 21;
    localparam int LINE_WIDTH      = 31;
    localparam int QUERY_WIDTH     = 32;

    localparam logic [CODE_WIDTH-1:0] CHAR_LF  = 21'h0000A;
    localparam logic [CODE_WIDTH-1:0] CHAR_CR  = 21'h0000D;
    localparam logic [CODE_WIDTH-1:0] CHAR_PS  = 21'h02029;
    localparam logic [CODE_WIDTH-1:0] BMP_LAST = 21'h0FFFF;

    localparam logic [LINE_WIDTH-1:0] LINE_MAX = 31'h7FFF_FFFF;

    // one decoded event per byte
    typedef struct packed {
        logic                  char_valid;
        logic                  zero_byte;
        logic [CODE_WIDTH-1:0] code;
    } t_char_evt;

endpackage

`default_nettype wire

@@ rtl/u16l_utf8_dec.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u16l_utf8_dec
// UTF-8 decoder: holds the partial character and the terminated flag, and
// flags each completed character or early zero byte.
// ----------------------------------------------------------------------------
module u16l_utf8_dec (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_byte_en,
    input  wire logic                 i_clear,
    input  wire logic [7:0]           i_data_byte,
    output u16l_pkg::t_char_evt       o_evt
);

    logic [u16l_pkg::CODE_WIDTH-1:0] r_acc, n_acc;
    logic [1:0]                      r_left, n_left;
    logic                            r_term, n_term;
    logic [u16l_pkg::CODE_WIDTH-1:0] cont_acc;

    assign cont_acc = {r_acc[u16l_pkg::CODE_WIDTH-7:0], i_data_byte[5:0]};

    always_comb begin
        n_acc  = r_acc;
        n_left = r_left;
        n_term = r_term;
        o_evt  = '0;
        if (i_clear) begin
            n_acc  = '0;
            n_left = '0;
            n_term = 1'b0;
        end else if (i_byte_en && !r_term) begin
            if (i_data_byte == 8'h00) begin
                n_acc           = '0;
                n_left          = '0;
                n_term          = 1'b1;
                o_evt.zero_byte = 1'b1;
            end else if (i_data_byte[7:6] == 2'b10) begin
                if (r_left == 2'd0) begin
                    o_evt.char_valid = 1'b1;
                    o_evt.code       = {13'd0, i_data_byte};
                end else begin
                    n_left = r_left - 2'd1;
                    if (r_left == 2'd1) begin
                        n_acc            = '0;
                        o_evt.char_valid = 1'b1;
                        o_evt.code       = cont_acc;
                    end else begin
                        n_acc = cont_acc;
                    end
                end
            end else begin
                n_acc  = '0;
                n_left = '0;
                if (!i_data_byte[7]) begin
                    o_evt.char_valid = 1'b1;
                    o_evt.code       = {13'd0, i_data_byte};
                end else if (i_data_byte[7:5] == 3'b110) begin
                    n_acc  = {16'd0, i_data_byte[4:0]};
                    n_left = 2'd1;
                end else if (i_data_byte[7:4] == 4'b1110) begin
                    n_acc  = {17'd0, i_data_byte[3:0]};
                    n_left = 2'd2;
                end else if (i_data_byte[7:3] == 5'b11110) begin
                    n_acc  = {18'd0, i_data_byte[2:0]};
                    n_left = 2'd3;
                end else begin
                    // invalid lead byte: one-byte character
                    o_evt.char_valid = 1'b1;
                    o_evt.code       = {13'd0, i_data_byte};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_left <= '0;
            r_term <= 1'b0;
        end else begin
            r_acc  <= n_acc;
            r_left <= n_left;
            r_term <= n_term;
        end
    end

endmodule

`default_nettype wire

@@ rtl/u16l_counter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u16l_counter
// UTF-16 unit and line counter with CR pairing and freeze at the query index.
// ----------------------------------------------------------------------------
module u16l_counter #(
    parameter int COUNT_WIDTH = u16l_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic signed [u16l_pkg::QUERY_WIDTH-1:0] i_query_index,
    input  wire u16l_pkg::t_char_evt                 i_evt,
    input  wire logic                                i_end,
    output logic [u16l_pkg::LINE_WIDTH-1:0]          o_line
);

    localparam int SW = COUNT_WIDTH + 2;
    localparam int EW = (SW > u16l_pkg::QUERY_WIDTH) ? SW : u16l_pkg::QUERY_WIDTH;

    logic [COUNT_WIDTH-1:0]          r_units, n_units;
    logic [u16l_pkg::LINE_WIDTH-1:0] r_lines, n_lines;
    logic                            r_stopped, n_stopped;
    logic                            r_cr, n_cr;

    logic                            is_lf, is_cr, pair;
    logic                            do_a, do_b, brk_b;
    logic [1:0]                      units_b;
    logic [SW-1:0]                   sum_a, sum_b;
    logic [EW-1:0]                   q_ext;
    logic                            q_neg, stop_a, stop_b;
    logic                            ok_a, go_b, ok_b;
    logic [u16l_pkg::LINE_WIDTH-1:0] lines_a;

    assign is_lf = (i_evt.code == u16l_pkg::CHAR_LF);
    assign is_cr = (i_evt.code == u16l_pkg::CHAR_CR);
    assign pair  = i_evt.char_valid && r_cr && is_lf;

    // lone CR before another character, a zero byte or the end
    assign do_a = r_cr && ((i_evt.char_valid && !is_lf) || i_evt.zero_byte || i_end);

    always_comb begin
        do_b    = 1'b0;
        brk_b   = 1'b0;
        units_b = 2'd1;
        if (i_evt.char_valid) begin
            if (pair) begin
                do_b    = 1'b1;
                brk_b   = 1'b1;
                units_b = 2'd2;
            end else if (!is_cr) begin
                do_b  = 1'b1;
                brk_b = is_lf || (i_evt.code == u16l_pkg::CHAR_PS);
                if (i_evt.code > u16l_pkg::BMP_LAST) begin
                    units_b = 2'd2;
                end
            end
        end
    end

    assign q_neg = i_query_index[u16l_pkg::QUERY_WIDTH-1];
    assign q_ext = {{(EW-u16l_pkg::QUERY_WIDTH+1){1'b0}},
                    i_query_index[u16l_pkg::QUERY_WIDTH-2:0]};

    assign sum_a = {2'b00, r_units} + {{(SW-1){1'b0}}, 1'b1};
    assign sum_b = {2'b00, r_units} + {{(SW-2){1'b0}}, units_b}
                   + {{(SW-1){1'b0}}, (do_a && !r_stopped)};

    assign stop_a = q_neg || (EW'(sum_a) > q_ext) || (sum_a[SW-1:COUNT_WIDTH] != 2'b00);
    assign stop_b = q_neg || (EW'(sum_b) > q_ext) || (sum_b[SW-1:COUNT_WIDTH] != 2'b00);

    assign ok_a = do_a && !r_stopped && !stop_a;
    assign go_b = do_b && !r_stopped && !(do_a && stop_a);
    assign ok_b = go_b && !stop_b;

    assign lines_a = (ok_a && r_lines != u16l_pkg::LINE_MAX) ? r_lines + 31'd1 : r_lines;
    assign o_line  = lines_a;

    always_comb begin
        n_units   = r_units;
        n_lines   = lines_a;
        n_stopped = r_stopped || (do_a && !r_stopped && stop_a) || (go_b && stop_b);
        n_cr      = r_cr;
        if (ok_b) begin
            n_units = sum_b[COUNT_WIDTH-1:0];
        end else if (ok_a) begin
            n_units = sum_a[COUNT_WIDTH-1:0];
        end
        if (ok_b && brk_b && lines_a != u16l_pkg::LINE_MAX) begin
            n_lines = lines_a + 31'd1;
        end
        if (i_evt.char_valid) begin
            n_cr = is_cr;
        end else if (i_evt.zero_byte) begin
            n_cr = 1'b0;
        end
        if (i_end) begin
            n_units   = '0;
            n_lines   = 31'd1;
            n_stopped = 1'b0;
            n_cr      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_units   <= '0;
            r_lines   <= 31'd1;
            r_stopped <= 1'b0;
            r_cr      <= 1'b0;
        end else begin
            r_units   <= n_units;
            r_lines   <= n_lines;
            r_stopped <= n_stopped;
            r_cr      <= n_cr;
        end
    end

endmodule

`default_nettype wire

@@ rtl/utf16_index_to_line_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf16_index_to_line_unit
// Streams UTF-8 bytes and reports the line on which a UTF-16 index falls.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while o_in_ready is high; each byte updates the
//   decoder and counters in the cycle it is accepted.
// Result: the line number appears in the output register in the cycle after the
//   end item is accepted.
// Reset: synchronous active low; clears the text state and the output valid
//   flag, and sets the query index to zero.
module utf16_index_to_line_unit #(
    parameter int COUNT_WIDTH = u16l_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [u16l_pkg::QUERY_WIDTH-1:0]    i_cfg_wr_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [7:0]                          i_data_byte,
    input  wire logic                                i_end_of_text,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [u16l_pkg::LINE_WIDTH-1:0]          o_line_number
);

    logic signed [u16l_pkg::QUERY_WIDTH-1:0] r_query;
    logic                                    r_out_valid, n_out_valid;
    logic [u16l_pkg::LINE_WIDTH-1:0]         r_line;
    logic                                    accept, byte_en, end_en;
    u16l_pkg::t_char_evt                     evt;
    logic [u16l_pkg::LINE_WIDTH-1:0]         line_res;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign byte_en    = accept && !i_end_of_text;
    assign end_en     = accept && i_end_of_text;

    u16l_utf8_dec u_dec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte_en   (byte_en),
        .i_clear     (end_en),
        .i_data_byte (i_data_byte),
        .o_evt       (evt)
    );

    u16l_counter #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cnt (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_query_index (r_query),
        .i_evt         (evt),
        .i_end         (end_en),
        .o_line        (line_res)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (end_en) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_query <= i_cfg_wr_data;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (end_en) begin
            r_line <= line_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_line_number = r_line;

endmodule

`default_nettype wire

@@ rtl/u16l_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u16l_checker
// Port-level checks for the UTF-16 index to line unit.
// ----------------------------------------------------------------------------
module u16l_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        o_in_ready,
    input wire logic                        i_end_of_text,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [u16l_pkg::LINE_WIDTH-1:0] o_line_number
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_line_number))
        else $error("stalled result changed");

    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_end_of_text |=> o_out_valid)
        else $error("end item gave no result");

    a_byte_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !i_end_of_text && !o_out_valid |=> !o_out_valid)
        else $error("byte item gave a result");

    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_line_number != '0)
        else $error("line number zero");

endmodule

bind utf16_index_to_line_unit u16l_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_end_of_text (i_end_of_text),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_line_number (o_line_number)
);

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for utf16_index_to_line_unit. UTF-8 texts are streamed
// byte by byte, each closed by an end item, under several query indices and
// handshake idling patterns. A line predictor tracks the decoder and UTF-16
// counters and each returned line number is checked in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int     CW            = u16l_pkg::COUNT_WIDTH_DEF;
    localparam longint UNIT_LIMIT    = (64'sd1 <<< CW) - 64'sd1;
    localparam int     CYCLE_LIMIT   = 400000;
    localparam int     SETTLE_CYCLES = 4;
    localparam int     MAX_GAP       = 20;
    localparam int     PHASE_ITEMS   = 300;

    localparam logic [u16l_pkg::QUERY_WIDTH-1:0] QUERY_MOST_NEG = 32'h8000_0000;
    localparam logic [u16l_pkg::QUERY_WIDTH-1:0] QUERY_MOST_POS = 32'h7FFF_FFFF;
    localparam logic [u16l_pkg::QUERY_WIDTH-1:0] QUERY_MINUS_1  = 32'hFFFF_FFFF;

    localparam bit [7:0]  BYTE_NUL = 8'h00;
    localparam bit [7:0]  BYTE_LF  = u16l_pkg::CHAR_LF[7:0];
    localparam bit [7:0]  BYTE_CR  = u16l_pkg::CHAR_CR[7:0];
    localparam bit [23:0] PS_UTF8  = 24'hE2_80_A9;  // U+2029 encoded

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_cfg_wr_en;
    logic [u16l_pkg::QUERY_WIDTH-1:0]  i_cfg_wr_data;
    logic                              i_in_valid;
    logic                              o_in_ready;
    logic [7:0]                        i_data_byte;
    logic                              i_end_of_text;
    logic                              o_out_valid;
    logic                              i_out_ready;
    logic [u16l_pkg::LINE_WIDTH-1:0]   o_line_number;

    utf16_index_to_line_unit #(
        .COUNT_WIDTH(CW)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_byte   (i_data_byte),
        .i_end_of_text (i_end_of_text),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_line_number (o_line_number)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // line predictor state
    int                              query_idx;
    logic [CW-1:0]                   ln_units;
    logic [u16l_pkg::LINE_WIDTH-1:0] ln_line;
    bit                              ln_frozen;
    bit                              ln_cr_wait;
    bit                              ln_ended;
    logic [u16l_pkg::CODE_WIDTH-1:0] ln_code;
    logic [1:0]                      ln_cont_left;

    logic [u16l_pkg::LINE_WIDTH-1:0] expected_lines[$];
    logic [u16l_pkg::LINE_WIDTH-1:0] line_want;
    bit [7:0]                        text_bytes[$];

    int err_count;
    int idle_pct;
    int stall_pct;
    int cycle_count;
    int counted_items;

    function automatic void clear_text();
        ln_units     = '0;
        ln_line      = 31'd1;
        ln_frozen    = 1'b0;
        ln_cr_wait   = 1'b0;
        ln_ended     = 1'b0;
        ln_code      = '0;
        ln_cont_left = '0;
    endfunction

    function automatic void count_units(input bit is_break, input int units);
        longint nxt;
        nxt = ln_units;
        nxt = nxt + units;
        if (ln_frozen)
            return;
        if (nxt > longint'(query_idx) || nxt > UNIT_LIMIT) begin
            ln_frozen = 1'b1;
            return;
        end
        ln_units = nxt[CW-1:0];
        if (is_break && ln_line != u16l_pkg::LINE_MAX)
            ln_line++;
    endfunction

    function automatic void lone_cr();
        if (ln_cr_wait) begin
            ln_cr_wait = 1'b0;
            count_units(1'b1, 1);
        end
    endfunction

    function automatic void take_char(input logic [u16l_pkg::CODE_WIDTH-1:0] c);
        if (ln_cr_wait) begin
            ln_cr_wait = 1'b0;
            if (c == u16l_pkg::CHAR_LF) begin
                count_units(1'b1, 2);
                return;
            end
            count_units(1'b1, 1);
        end
        if (c == u16l_pkg::CHAR_CR) begin
            ln_cr_wait = 1'b1;
            return;
        end
        if (c == u16l_pkg::CHAR_LF || c == u16l_pkg::CHAR_PS) begin
            count_units(1'b1, 1);
            return;
        end
        count_units(1'b0, (c > u16l_pkg::BMP_LAST) ? 2 : 1);
    endfunction

    function automatic void take_byte(input logic [7:0] b);
        logic [u16l_pkg::CODE_WIDTH-1:0] c;
        if (b == BYTE_NUL) begin
            ln_cont_left = '0;
            ln_code      = '0;
            lone_cr();
            ln_ended     = 1'b1;
            return;
        end
        if (b[7:6] == 2'b10) begin
            if (ln_cont_left == 0) begin
                take_char(u16l_pkg::CODE_WIDTH'(b));
                return;
            end
            ln_code = {ln_code[u16l_pkg::CODE_WIDTH-7:0], b[5:0]};
            ln_cont_left--;
            if (ln_cont_left == 0) begin
                c       = ln_code;
                ln_code = '0;
                take_char(c);
            end
            return;
        end
        ln_cont_left = '0;
        ln_code      = '0;
        if (!b[7]) begin
            take_char(u16l_pkg::CODE_WIDTH'(b));
        end else if (b[7:5] == 3'b110) begin
            ln_code      = u16l_pkg::CODE_WIDTH'(b[4:0]);
            ln_cont_left = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
            ln_code      = u16l_pkg::CODE_WIDTH'(b[3:0]);
            ln_cont_left = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
            ln_code      = u16l_pkg::CODE_WIDTH'(b[2:0]);
            ln_cont_left = 2'd3;
        end else begin
            take_char(u16l_pkg::CODE_WIDTH'(b));
        end
    endfunction

    // returns 0 for a byte that falls after a zero byte
    function automatic bit predict_line(input logic [7:0] b, input bit eot);
        if (eot) begin
            if (!ln_ended)
                lone_cr();
            expected_lines.push_back(ln_line);
            clear_text();
            return 1'b1;
        end
        if (ln_ended)
            return 1'b0;
        take_byte(b);
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        err_count++;
        $display("ERROR at %0t: %s", $time, what);
    endtask

    task automatic send_item(input bit [7:0] b, input bit eot);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid  <= 1'b0;
            i_data_byte <= 8'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_data_byte   <= b;
        i_end_of_text <= eot;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        if (predict_line(b, eot))
            counted_items++;
    endtask

    task automatic send_text();
        foreach (text_bytes[i])
            send_item(text_bytes[i], 1'b0);
        send_item(8'($urandom), 1'b1);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_lines.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_query(input logic [u16l_pkg::QUERY_WIDTH-1:0] v);
        wait_idle();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        query_idx = int'(v);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    function automatic void add_conts(input int k);
        repeat (k) text_bytes.push_back(8'h80 | 8'($urandom_range(63)));
    endfunction

    // mostly well-formed UTF-8 with line breaks, plus malformed sequences
    function automatic void make_text();
        int n;
        int r;
        int need;
        text_bytes.delete();
        n = ($urandom_range(15) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 30) begin
                text_bytes.push_back(8'($urandom_range(1, 127)));
            end else if (r < 40) begin
                text_bytes.push_back(BYTE_LF);
            end else if (r < 47) begin
                text_bytes.push_back(BYTE_CR);
            end else if (r < 53) begin
                text_bytes.push_back(BYTE_CR);
                text_bytes.push_back(BYTE_LF);
            end else if (r < 61) begin
                text_bytes.push_back(8'hC0 | 8'($urandom_range(31)));
                add_conts(1);
            end else if (r < 69) begin
                if ($urandom_range(3) == 0) begin
                    text_bytes.push_back(PS_UTF8[23:16]);
                    text_bytes.push_back(PS_UTF8[15:8]);
                    text_bytes.push_back(PS_UTF8[7:0]);
                end else begin
                    text_bytes.push_back(8'hE0 | 8'($urandom_range(15)));
                    add_conts(2);
                end
            end else if (r < 76) begin
                text_bytes.push_back(8'hF0 | 8'($urandom_range(7)));
                add_conts(3);
            end else if (r < 81) begin
                add_conts(1);
            end else if (r < 85) begin
                text_bytes.push_back(8'($urandom_range(8'hF8, 8'hFF)));
            end else if (r < 91) begin
                need = $urandom_range(1, 3);
                case (need)
                    1: text_bytes.push_back(8'hC0 | 8'($urandom_range(31)));
                    2: text_bytes.push_back(8'hE0 | 8'($urandom_range(15)));
                    default: text_bytes.push_back(8'hF0 | 8'($urandom_range(7)));
                endcase
                add_conts($urandom_range(0, need - 1));
            end else if (r < 93) begin
                text_bytes.push_back(BYTE_NUL);
            end else begin
                text_bytes.push_back(8'($urandom_range(255)));
            end
        end
    endfunction

    function automatic logic [u16l_pkg::QUERY_WIDTH-1:0] pick_extreme();
        case ($urandom_range(3))
            0: return QUERY_MOST_NEG;
            1: return QUERY_MOST_POS;
            2: return QUERY_MINUS_1;
            default: return '0;
        endcase
    endfunction

    task automatic run_random_text(input bit new_query);
        int q;
        make_text();
        if (new_query || $urandom_range(2) == 0) begin
            if ($urandom_range(9) == 0)
                q = int'(pick_extreme());
            else
                q = $urandom_range(0, text_bytes.size() + 3) - 2;
            set_query(q);
        end
        send_text();
    endtask

    // LF, CRLF, lone CR, U+2029, astral character, stray continuation,
    // invalid lead, CR and partial character left open at the end
    task automatic test_line_breaks();
        set_query(QUERY_MOST_POS);
        text_bytes = '{8'h61, BYTE_LF, BYTE_CR, BYTE_LF, BYTE_CR, 8'h62,
                       PS_UTF8[23:16], PS_UTF8[15:8], PS_UTF8[7:0],
                       8'hF0, 8'h9F, 8'h98, 8'h80, 8'h80, 8'hFF, BYTE_CR,
                       8'hF0, 8'h9F};
        send_text();
    endtask

    // interrupted sequence, then a CR resolved by a zero byte past the index
    task automatic test_early_stop();
        set_query(2);
        text_bytes = '{8'hE2, 8'hC3, 8'hA9, BYTE_LF, BYTE_CR, BYTE_NUL};
        send_text();
    endtask

    task automatic test_query_extremes();
        logic [u16l_pkg::QUERY_WIDTH-1:0] picks[5];
        picks = '{QUERY_MOST_NEG, QUERY_MINUS_1, '0, 32'd1, QUERY_MOST_POS};
        foreach (picks[i]) begin
            set_query(picks[i]);
            make_text();
            send_text();
        end
    endtask

    task automatic test_random_texts();
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 60; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 60; end
                default: begin idle_pct = 18; stall_pct = 18; end
            endcase
            counted_items = 0;
            run_random_text(1'b1);
            while (counted_items < PHASE_ITEMS)
                run_random_text(1'b0);
        end
    endtask

    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_lines.size() == 0) begin
                report_mismatch($sformatf("line %0d with no result expected", o_line_number));
            end else begin
                line_want = expected_lines.pop_front();
                if (o_line_number !== line_want)
                    report_mismatch($sformatf("line_number %0d, expected %0d",
                                              o_line_number, line_want));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_in_valid    = 1'b0;
        i_data_byte   = '0;
        i_end_of_text = 1'b0;
        i_out_ready   = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        err_count     = 0;
        query_idx     = 0;
        clear_text();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_line_breaks();
        test_early_stop();
        test_query_extremes();
        test_random_texts();

        wait_idle();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
